// ----- design/td4ie_pkg.sv -----
// Shared types and constants for the 4-bit two-register instruction execute core.
// Holds the opcode codes, the configuration register indexes and the stage structs.
// No dependencies.
`default_nettype none

package td4ie_pkg;

    localparam int NIB_W     = 4;
    localparam int LEN_W     = 5;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 5;
    localparam int S_DATA_W  = 8;
    localparam int M_DATA_W  = 24;

    localparam logic [LEN_W-1:0] PROG_LEN_RESET = 5'd16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PROG_LEN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IN_PORT_A = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IN_PORT_B = 2'd2;

    typedef enum logic [NIB_W-1:0] {
        OP_ADD_A_IM = 4'd0,
        OP_MOV_A_B  = 4'd1,
        OP_IN_A     = 4'd2,
        OP_MOV_A_IM = 4'd3,
        OP_MOV_B_A  = 4'd4,
        OP_ADD_B_IM = 4'd5,
        OP_IN_B     = 4'd6,
        OP_MOV_B_IM = 4'd7,
        OP_OUT_B    = 4'd9,
        OP_OUT_IM   = 4'd11,
        OP_JNC      = 4'd14,
        OP_JMP      = 4'd15
    } t_opcode;

    typedef struct packed {
        logic [LEN_W-1:0] program_length;
        logic [NIB_W-1:0] in_port_a;
        logic [NIB_W-1:0] in_port_b;
    } t_cfg;

    typedef struct packed {
        logic [NIB_W-1:0] immediate;
        logic [NIB_W-1:0] opcode;
    } t_instr;

    typedef struct packed {
        logic [NIB_W-1:0] out_port_value;
        logic             carry_out;
        logic [NIB_W-1:0] reg_b_value;
        logic [NIB_W-1:0] reg_a_value;
        logic [NIB_W-1:0] next_pc;
    } t_result;

endpackage

`default_nettype wire

// ----- design/td4ie_cfg.sv -----
// Configuration register file: program length and the two input port values.
// Depends on td4ie_pkg.
`default_nettype none

module td4ie_cfg
    import td4ie_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_wr_en,
    input  wire logic [CFG_IDX_W-1:0] i_wr_index,
    input  wire logic [CFG_DAT_W-1:0] i_wr_data,
    output t_cfg                      o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_wr_en) begin
            unique case (i_wr_index)
                CFG_PROG_LEN:  n_cfg.program_length = i_wr_data[LEN_W-1:0];
                CFG_IN_PORT_A: n_cfg.in_port_a      = i_wr_data[NIB_W-1:0];
                CFG_IN_PORT_B: n_cfg.in_port_b      = i_wr_data[NIB_W-1:0];
                default:       n_cfg                = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.program_length <= PROG_LEN_RESET;
            r_cfg.in_port_a      <= '0;
            r_cfg.in_port_b      <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ----- design/td4ie_in_reg.sv -----
// Input register stage: captures one instruction word and holds it until execute takes it.
// Depends on td4ie_pkg.
`default_nettype none

module td4ie_in_reg
    import td4ie_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_valid,
    output logic        o_ready,
    input  t_instr      i_instr,
    output logic        o_valid,
    input  wire logic   i_take,
    output t_instr      o_instr
);

    logic   r_valid;
    t_instr r_instr;

    // full register may refill in the same cycle it is drained
    assign o_ready = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_instr <= i_instr;
        end
    end

    assign o_valid = r_valid;
    assign o_instr = r_instr;

endmodule

`default_nettype wire

// ----- design/td4ie_exec.sv -----
// Execute stage: machine state (A, B, carry, pc, output latch) and the result register.
// Depends on td4ie_pkg.
`default_nettype none

module td4ie_exec
    import td4ie_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  t_cfg        i_cfg,
    input  wire logic   i_valid,
    input  t_instr      i_instr,
    output logic        o_take,
    output logic        o_res_valid,
    input  wire logic   i_res_ready,
    output t_result     o_res
);

    logic [NIB_W-1:0] r_a, r_b, r_pc, r_out;
    logic             r_carry;
    logic [NIB_W-1:0] n_a, n_b, n_pc, n_out;
    logic             n_carry;
    logic [LEN_W-1:0] npc;
    logic [NIB_W:0]   sum_a, sum_b;
    logic             r_res_valid;
    t_result          r_res;
    logic             fire;

    assign o_take = !r_res_valid || i_res_ready;
    assign fire   = i_valid && o_take;

    assign sum_a = {1'b0, r_a} + {1'b0, i_instr.immediate};
    assign sum_b = {1'b0, r_b} + {1'b0, i_instr.immediate};

    always_comb begin
        n_a     = r_a;
        n_b     = r_b;
        n_out   = r_out;
        n_carry = 1'b0;
        npc     = {1'b0, r_pc} + LEN_W'(1);
        unique case (i_instr.opcode)
            OP_ADD_A_IM: begin
                n_a     = sum_a[NIB_W-1:0];
                n_carry = sum_a[NIB_W];
            end
            OP_ADD_B_IM: begin
                n_b     = sum_b[NIB_W-1:0];
                n_carry = sum_b[NIB_W];
            end
            OP_MOV_A_IM: n_a   = i_instr.immediate;
            OP_MOV_B_IM: n_b   = i_instr.immediate;
            OP_MOV_A_B:  n_a   = r_b;
            OP_MOV_B_A:  n_b   = r_a;
            OP_IN_A:     n_a   = i_cfg.in_port_a;
            OP_IN_B:     n_b   = i_cfg.in_port_b;
            OP_OUT_B:    n_out = r_b;
            OP_OUT_IM:   n_out = i_instr.immediate;
            OP_JMP:      npc   = {1'b0, i_instr.immediate};
            OP_JNC: begin
                if (!r_carry) begin
                    npc = {1'b0, i_instr.immediate};
                end
            end
            default: begin
                // undefined code: hold everything, pc still goes through the wrap check
                n_carry = r_carry;
                npc     = {1'b0, r_pc};
            end
        endcase
        n_pc = (npc >= i_cfg.program_length) ? '0 : npc[NIB_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a         <= '0;
            r_b         <= '0;
            r_pc        <= '0;
            r_out       <= '0;
            r_carry     <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            if (fire) begin
                r_a     <= n_a;
                r_b     <= n_b;
                r_pc    <= n_pc;
                r_out   <= n_out;
                r_carry <= n_carry;
            end
            if (o_take) begin
                r_res_valid <= i_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_res.next_pc        <= n_pc;
            r_res.reg_a_value    <= n_a;
            r_res.reg_b_value    <= n_b;
            r_res.carry_out      <= n_carry;
            r_res.out_port_value <= n_out;
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

endmodule

`default_nettype wire

// ----- design/td4_instruction_execute_core.sv -----
// Top level of the 4-bit two-register instruction execute core.
// Depends on td4ie_pkg, td4ie_cfg, td4ie_in_reg and td4ie_exec.
//
// Each input word is one fetched instruction; the core executes it and returns one
// word with the machine state afterward (pc, A, B, carry, output latch). One
// instruction is taken every clock while the result output is not stalled; after
// acceptance it is held in the input register, then execute writes its result into the
// result register. The rate is set by the execute stage, which computes the new machine
// state combinationally from the current one. Configuration writes are always accepted
// and take effect on the next clock; write them only while no instruction is in flight.
`default_nettype none

module td4_instruction_execute_core
    import td4ie_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_s_tvalid,
    output logic                      o_s_tready,
    input  wire logic [S_DATA_W-1:0]  i_s_tdata,   // [3:0] opcode, [7:4] immediate
    output logic                      o_m_tvalid,
    input  wire logic                 i_m_tready,
    output logic [M_DATA_W-1:0]       o_m_tdata,   // [3:0] next_pc, [7:4] reg_a_value,
                                                   // [11:8] reg_b_value, [12] carry_out,
                                                   // [16:13] out_port_value, rest zero
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_DAT_W-1:0] i_cfg_data
);

    t_cfg    cfg;
    t_instr  in_instr;
    t_instr  ex_instr;
    t_result res;
    logic    ex_valid;
    logic    ex_take;

    assign o_cfg_ready = 1'b1;
    assign in_instr    = t_instr'(i_s_tdata);

    td4ie_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (cfg)
    );

    td4ie_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_instr (in_instr),
        .o_valid (ex_valid),
        .i_take  (ex_take),
        .o_instr (ex_instr)
    );

    td4ie_exec u_exec (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_valid     (ex_valid),
        .i_instr     (ex_instr),
        .o_take      (ex_take),
        .o_res_valid (o_m_tvalid),
        .i_res_ready (i_m_tready),
        .o_res       (res)
    );

    assign o_m_tdata = {{(M_DATA_W - $bits(t_result)){1'b0}}, res};

endmodule

`default_nettype wire
